// ----- hdl/cfd_pkg.sv -----
`timescale 1ns / 1ps

package cfd_pkg;

   // Frame store geometry.
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 256;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(DEPTH);

   // Effective limits hold values up to and including the maximum.
   localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
   localparam int LIM_W    = (WIDTH_W > HEIGHT_W) ? WIDTH_W : HEIGHT_W;

   // On-screen coordinates.
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COORD_W = (COL_W > ROW_W) ? COL_W : ROW_W;

   // Item fields.
   localparam int CMD_W   = 2;
   localparam int POS_W   = 16;
   localparam int LEN_W   = 16;
   localparam int COLOR_W = 16;
   localparam int COUNT_W = 10;

   // Signed width for the clipping arithmetic: a 16-bit start plus a 16-bit length.
   localparam int CLIP_W = 18;

   // Configuration port.
   localparam int CSR_W        = 10;
   localparam int CSR_IDX_W    = 1;
   localparam int CFG_WIDTH_W  = 10;
   localparam int CFG_HEIGHT_W = 9;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

   localparam int RST_WIDTH  = (320 > MAX_WIDTH) ? MAX_WIDTH : 320;
   localparam int RST_HEIGHT = (240 > MAX_HEIGHT) ? MAX_HEIGHT : 240;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HSPAN = 2'd2;
   localparam logic [CMD_W-1:0] CMD_VSPAN = 2'd3;

endpackage

// ----- hdl/cfd_req_if.sv -----
`timescale 1ns / 1ps

interface cfd_req_if;
   logic                                valid;
   logic                                ready;
   logic [cfd_pkg::CMD_W-1:0]           command;
   logic signed [cfd_pkg::POS_W-1:0]    pos_x;
   logic signed [cfd_pkg::POS_W-1:0]    pos_y;
   logic [cfd_pkg::LEN_W-1:0]           span_length;
   logic [cfd_pkg::COLOR_W-1:0]         pixel_color;

   modport source (output valid, command, pos_x, pos_y, span_length, pixel_color,
                   input ready);
   modport sink (input valid, command, pos_x, pos_y, span_length, pixel_color,
                 output ready);
endinterface

// ----- hdl/cfd_rsp_if.sv -----
`timescale 1ns / 1ps

interface cfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cfd_pkg::COLOR_W-1:0]   read_color;
   logic [cfd_pkg::COUNT_W-1:0]   pixels_written;

   modport source (output valid, read_color, pixels_written, input ready);
   modport sink (input valid, read_color, pixels_written, output ready);
endinterface

// ----- hdl/cfd_ram.sv -----
`timescale 1ns / 1ps

module cfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/clipped_framebuffer_draw_top.sv -----
`timescale 1ns / 1ps

// Channel    Role     Payload
// req_chan   sink     command, pos_x, pos_y, span_length, pixel_color
// rsp_chan   source   read_color, pixels_written
// csr_*      write    csr_write_enable, csr_index, csr_write_data
//
// One item is in work at a time. It passes through the clip, address, sweep and
// done steps; a span sweeps its clipped length through the single frame store
// port, which takes one pixel write per cycle. The next item can be taken in the
// cycle after the result is registered. The result sits in an output register,
// so the next item is taken while it waits. Reset is synchronous and sets the
// control state idle and the size registers to 320 by 240; the frame store is
// not cleared. A stalled result holds the sequencer in its final step.

module clipped_framebuffer_draw_top (
   input  logic                           clock,
   input  logic                           reset,
   cfd_req_if.sink                        req_chan,
   cfd_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [cfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfd_pkg::CSR_W-1:0]      csr_write_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CLIP = 5'b00010,
      ST_ADDR = 5'b00100,
      ST_RUN  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Size registers, saturated at write time.
   logic [cfd_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [cfd_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [cfd_pkg::CFG_WIDTH_W-1:0]  cfg_width;
   logic [cfd_pkg::CFG_HEIGHT_W-1:0] cfg_height;

   // Captured item.
   logic [cfd_pkg::CMD_W-1:0]        cmd_ff;
   logic signed [cfd_pkg::POS_W-1:0] x_ff, y_ff;
   logic [cfd_pkg::LEN_W-1:0]        len_ff;
   logic [cfd_pkg::COLOR_W-1:0]      color_ff;

   // Clipping results.
   logic                         live_ff, live_in;
   logic [cfd_pkg::COORD_W-1:0]  first_ff, first_in;
   logic [cfd_pkg::COORD_W-1:0]  other_ff, other_in;
   logic [cfd_pkg::LIM_W-1:0]    endc_ff, endc_in;

   // Write sweep.
   logic [cfd_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [cfd_pkg::ADDR_W-1:0]   stride_ff, stride_in;
   logic [cfd_pkg::LIM_W-1:0]    remaining_ff, remaining_in;
   logic [cfd_pkg::LIM_W-1:0]    count_ff, count_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cfd_pkg::COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [cfd_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic req_take;
   logic rsp_free;
   logic is_vert, is_span, is_read;

   logic signed [cfd_pkg::POS_W-1:0]  run_start, other_pos;
   logic [cfd_pkg::LEN_W-1:0]         run_len;
   logic [cfd_pkg::LIM_W-1:0]         lim_run, lim_other;
   logic signed [cfd_pkg::CLIP_W-1:0] start_s, len_s, end_s, lim_s, first_s, endc_s;
   logic                              other_ok;

   logic [cfd_pkg::ROW_W-1:0]                  row;
   logic [cfd_pkg::COL_W-1:0]                  col;
   logic [cfd_pkg::ROW_W+cfd_pkg::WIDTH_W-1:0] prod;
   logic [cfd_pkg::ROW_W+cfd_pkg::WIDTH_W-1:0] addr_sum;

   logic                          ram_we, ram_re;
   logic [cfd_pkg::COLOR_W-1:0]   ram_rdata;

   cfd_ram #(
      .WIDTH (cfd_pkg::COLOR_W),
      .DEPTH (cfd_pkg::DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (addr_ff),
      .wdata (color_ff),
      .rdata (ram_rdata)
   );

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign req_take                = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free                = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_color     = rsp_color_ff;
   assign rsp_chan.pixels_written = rsp_count_ff;

   assign is_vert = (cmd_ff == cfd_pkg::CMD_VSPAN);
   assign is_span = (cmd_ff == cfd_pkg::CMD_HSPAN) || (cmd_ff == cfd_pkg::CMD_VSPAN);
   assign is_read = (cmd_ff == cfd_pkg::CMD_READ);

   // Size register saturation.
   always_comb begin
      cfg_width  = csr_write_data[cfd_pkg::CFG_WIDTH_W-1:0];
      cfg_height = csr_write_data[cfd_pkg::CFG_HEIGHT_W-1:0];
      if (int'(cfg_width) > cfd_pkg::MAX_WIDTH) begin
         width_in = cfd_pkg::WIDTH_W'(cfd_pkg::MAX_WIDTH);
      end else begin
         width_in = cfd_pkg::WIDTH_W'(cfg_width);
      end
      if (int'(cfg_height) > cfd_pkg::MAX_HEIGHT) begin
         height_in = cfd_pkg::HEIGHT_W'(cfd_pkg::MAX_HEIGHT);
      end else begin
         height_in = cfd_pkg::HEIGHT_W'(cfg_height);
      end
   end

   // Clipping. A single pixel is a horizontal run of length one; the run axis
   // is clipped to [0, limit) and the cross axis must lie on screen.
   always_comb begin
      run_start = is_vert ? y_ff : x_ff;
      other_pos = is_vert ? x_ff : y_ff;
      run_len   = is_span ? len_ff : cfd_pkg::LEN_W'(1);
      lim_run   = is_vert ? cfd_pkg::LIM_W'(height_ff) : cfd_pkg::LIM_W'(width_ff);
      lim_other = is_vert ? cfd_pkg::LIM_W'(width_ff) : cfd_pkg::LIM_W'(height_ff);

      start_s = {{(cfd_pkg::CLIP_W - cfd_pkg::POS_W){run_start[cfd_pkg::POS_W-1]}},
                 run_start};
      len_s   = {{(cfd_pkg::CLIP_W - cfd_pkg::LEN_W){1'b0}}, run_len};
      lim_s   = {{(cfd_pkg::CLIP_W - cfd_pkg::LIM_W){1'b0}}, lim_run};
      end_s   = start_s + len_s;
      first_s = start_s[cfd_pkg::CLIP_W-1] ? '0 : start_s;
      endc_s  = (end_s < lim_s) ? end_s : lim_s;

      other_ok = !other_pos[cfd_pkg::POS_W-1] &&
                 (cfd_pkg::CLIP_W'(other_pos[cfd_pkg::POS_W-2:0]) <
                  cfd_pkg::CLIP_W'(lim_other));

      live_in  = other_ok && (endc_s > first_s);
      first_in = first_s[cfd_pkg::COORD_W-1:0];
      endc_in  = endc_s[cfd_pkg::LIM_W-1:0];
      other_in = other_pos[cfd_pkg::COORD_W-1:0];
   end

   // Start address and stride of the sweep.
   always_comb begin
      row      = is_vert ? first_ff[cfd_pkg::ROW_W-1:0] : other_ff[cfd_pkg::ROW_W-1:0];
      col      = is_vert ? other_ff[cfd_pkg::COL_W-1:0] : first_ff[cfd_pkg::COL_W-1:0];
      prod     = row * width_ff;
      addr_sum = prod + (cfd_pkg::ROW_W + cfd_pkg::WIDTH_W)'(col);
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      stride_in    = stride_ff;
      remaining_in = remaining_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_color_in = rsp_color_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (live_ff) begin
               count_in = endc_ff - cfd_pkg::LIM_W'(first_ff);
            end else begin
               count_in = '0;
            end
            remaining_in = count_in;
            addr_in      = addr_sum[cfd_pkg::ADDR_W-1:0];
            stride_in    = is_vert ? cfd_pkg::ADDR_W'(width_ff) : cfd_pkg::ADDR_W'(1);
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            if (is_read) begin
               ram_re   = (remaining_ff != '0);
               state_in = ST_DONE;
            end else if (remaining_ff != '0) begin
               ram_we       = 1'b1;
               addr_in      = addr_ff + stride_ff;
               remaining_in = remaining_ff - cfd_pkg::LIM_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (is_read && (count_ff != '0)) begin
                  rsp_color_in = ram_rdata;
               end else begin
                  rsp_color_in = '0;
               end
               rsp_count_in = is_read ? '0 : cfd_pkg::COUNT_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= cfd_pkg::WIDTH_W'(cfd_pkg::RST_WIDTH);
         height_ff    <= cfd_pkg::HEIGHT_W'(cfd_pkg::RST_HEIGHT);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && (csr_index == cfd_pkg::REG_ACTIVE_WIDTH)) begin
            width_ff <= width_in;
         end
         if (csr_write_enable && (csr_index == cfd_pkg::REG_ACTIVE_HEIGHT)) begin
            height_ff <= height_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= req_chan.command;
         x_ff     <= req_chan.pos_x;
         y_ff     <= req_chan.pos_y;
         len_ff   <= req_chan.span_length;
         color_ff <= req_chan.pixel_color;
      end
      if (state_ff == ST_CLIP) begin
         live_ff  <= live_in;
         first_ff <= first_in;
         endc_ff  <= endc_in;
         other_ff <= other_in;
      end
      addr_ff      <= addr_in;
      stride_ff    <= stride_in;
      remaining_ff <= remaining_in;
      count_ff     <= count_in;
      rsp_color_ff <= rsp_color_in;
      rsp_count_ff <= rsp_count_in;
   end

   // The frame store is touched only while a sweep runs.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (!ram_we && !ram_re))
      else $error("frame store accessed outside the sweep");

   // Each pixel write consumes one unit of the remaining count.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (remaining_ff == $past(remaining_ff) - cfd_pkg::LIM_W'(1)))
      else $error("remaining count did not step with a write");

   // A read item never writes the frame store.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && is_read) |-> !ram_we)
      else $error("read item wrote the frame store");

   // A horizontal run never covers more pixels than the active width.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && (cmd_ff == cfd_pkg::CMD_HSPAN)) |->
      (count_ff <= cfd_pkg::LIM_W'(width_ff)))
      else $error("horizontal run longer than the active width");

endmodule

// ----- test/clipped_framebuffer_draw_top_test.sv -----
`timescale 1ns / 1ps

module clipped_framebuffer_draw_top_test;

   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic [cfd_pkg::CMD_W-1:0]   command;
      logic [cfd_pkg::POS_W-1:0]   pos_x;
      logic [cfd_pkg::POS_W-1:0]   pos_y;
      logic [cfd_pkg::LEN_W-1:0]   span_length;
      logic [cfd_pkg::COLOR_W-1:0] pixel_color;
   } draw_cmd_type;

   typedef struct packed {
      logic [cfd_pkg::COLOR_W-1:0] read_color;
      logic [cfd_pkg::COUNT_W-1:0] pixels_written;
   } draw_result_type;

   class draw_scoreboard;
      logic [cfd_pkg::COLOR_W-1:0] pixels [cfd_pkg::DEPTH];
      bit                          written [cfd_pkg::DEPTH];
      int                          recent [256];
      int                          recent_count;
      int                          width_reg;
      int                          height_reg;
      int                          mismatches;
      draw_result_type             expected_q [$];

      function new();
         width_reg = 320;
         height_reg = 240;
         recent_count = 0;
         mismatches = 0;
      endfunction

      function int eff_width();
         return (width_reg > cfd_pkg::MAX_WIDTH) ? cfd_pkg::MAX_WIDTH : width_reg;
      endfunction

      function int eff_height();
         return (height_reg > cfd_pkg::MAX_HEIGHT) ? cfd_pkg::MAX_HEIGHT : height_reg;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void set_register(logic [cfd_pkg::CSR_IDX_W-1:0] idx,
                                 logic [cfd_pkg::CSR_W-1:0] data);
         if (idx == cfd_pkg::REG_ACTIVE_WIDTH) begin
            width_reg = int'(data[cfd_pkg::CFG_WIDTH_W-1:0]);
         end else begin
            height_reg = int'(data[cfd_pkg::CFG_HEIGHT_W-1:0]);
         end
      endfunction

      function void store_pixel(int addr, logic [cfd_pkg::COLOR_W-1:0] color);
         pixels[addr] = color;
         written[addr] = 1'b1;
         recent[recent_count % 256] = addr;
         recent_count++;
      endfunction

      // Returns a recently written address, or -1 if nothing was written yet.
      function int recent_address();
         if (recent_count == 0) begin
            return -1;
         end
         return recent[$urandom_range(0, ((recent_count < 256) ? recent_count : 256) - 1)];
      endfunction

      // Trims the run [start, start + len) to [0, lim).
      function int clip_span(int start, int len, int lim, output int origin);
         origin = 0;
         if (len <= 0) begin
            return 0;
         end
         if (start < 0) begin
            if (len <= -start) begin
               return 0;
            end
            len = len + start;
            start = 0;
         end
         if (start >= lim) begin
            return 0;
         end
         if (start + len > lim) begin
            len = lim - start;
         end
         origin = start;
         return len;
      endfunction

      function void note_command(draw_cmd_type c);
         int              x;
         int              y;
         int              len;
         int              w;
         int              h;
         int              origin;
         int              count;
         int              i;
         draw_result_type r;
         x = int'($signed(c.pos_x));
         y = int'($signed(c.pos_y));
         len = int'(c.span_length);
         w = eff_width();
         h = eff_height();
         r.read_color = '0;
         count = 0;
         origin = 0;
         case (c.command)
            cfd_pkg::CMD_WRITE, cfd_pkg::CMD_READ: begin
               if (x >= 0 && y >= 0 && x < w && y < h) begin
                  if (c.command == cfd_pkg::CMD_WRITE) begin
                     store_pixel(y * w + x, c.pixel_color);
                     count = 1;
                  end else begin
                     r.read_color = pixels[y * w + x];
                  end
               end
            end
            cfd_pkg::CMD_HSPAN: begin
               if (y >= 0 && y < h) begin
                  count = clip_span(x, len, w, origin);
                  for (i = 0; i < count; i++) begin
                     store_pixel(y * w + origin + i, c.pixel_color);
                  end
               end
            end
            default: begin
               if (x >= 0 && x < w) begin
                  count = clip_span(y, len, h, origin);
                  for (i = 0; i < count; i++) begin
                     store_pixel((origin + i) * w + x, c.pixel_color);
                  end
               end
            end
         endcase
         r.pixels_written = cfd_pkg::COUNT_W'(count);
         expected_q.push_back(r);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
      endfunction

      function void check_result(draw_result_type got);
         draw_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with no item waiting (read_color %h, pixels_written %0d)",
                             got.read_color, got.pixels_written));
            return;
         end
         want = expected_q.pop_front();
         if (got.read_color !== want.read_color) begin
            report($sformatf("read_color expected %h, got %h",
                             want.read_color, got.read_color));
         end
         if (got.pixels_written !== want.pixels_written) begin
            report($sformatf("pixels_written expected %0d, got %0d",
                             want.pixels_written, got.pixels_written));
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable;
   logic [cfd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cfd_pkg::CSR_W-1:0]     csr_write_data;
   int                            cycle_count = 0;
   draw_result_type               seen;
   draw_scoreboard                sb = new();

   cfd_req_if req_chan ();
   cfd_rsp_if rsp_chan ();

   clipped_framebuffer_draw_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.read_color = rsp_chan.read_color;
         seen.pixels_written = rsp_chan.pixels_written;
         sb.check_result(seen);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** clipped_framebuffer_draw_top: FAILED **");
      $finish;
   end

   // Result side: random stalls, with every fifth stretch of items taken at full rate.
   initial begin : rsp_backpressure
      int stall;
      int taken;
      rsp_chan.ready = 1'b0;
      taken = 0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         stall = ((taken / 25) % 5 == 2) ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
         @(negedge clock);
      end
   end

   function automatic draw_cmd_type make_cmd(logic [cfd_pkg::CMD_W-1:0] cmd, int x, int y,
                                             int len, int color);
      draw_cmd_type c;
      c.command = cmd;
      c.pos_x = cfd_pkg::POS_W'(x);
      c.pos_y = cfd_pkg::POS_W'(y);
      c.span_length = cfd_pkg::LEN_W'(len);
      c.pixel_color = cfd_pkg::COLOR_W'(color);
      return c;
   endfunction

   function automatic logic [cfd_pkg::POS_W-1:0] pick_coord(int lim);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            return (lim > 0) ? cfd_pkg::POS_W'($urandom_range(0, lim - 1)) :
                               cfd_pkg::POS_W'($urandom_range(0, 600));
         end
         5, 6:    return cfd_pkg::POS_W'($urandom_range(0, lim + 40) - 20);
         7:       return cfd_pkg::POS_W'(-$urandom_range(1, 600));
         8:       return cfd_pkg::POS_W'($urandom);
         default: return ($urandom_range(0, 1) != 0) ? cfd_pkg::POS_W'(lim) :
                                                       cfd_pkg::POS_W'(lim - 1);
      endcase
   endfunction

   function automatic logic [cfd_pkg::LEN_W-1:0] pick_length(int lim);
      case ($urandom_range(0, 9))
         0:             return '0;
         1, 2, 3, 4, 5: return cfd_pkg::LEN_W'($urandom_range(1, 32));
         6, 7:          return cfd_pkg::LEN_W'($urandom_range(1, lim + 20));
         8:             return cfd_pkg::LEN_W'($urandom);
         default:       return cfd_pkg::LEN_W'($urandom_range(1, 600));
      endcase
   endfunction

   // A read lands only on a pixel that holds a written color, or off screen.
   function automatic void pick_read(int w, int h, output logic [cfd_pkg::POS_W-1:0] x,
                                     output logic [cfd_pkg::POS_W-1:0] y);
      int a;
      x = cfd_pkg::POS_W'($urandom);
      y = cfd_pkg::POS_W'($urandom);
      if (w > 0 && h > 0 && $urandom_range(0, 6) != 0) begin
         repeat (4) begin
            a = int'($urandom_range(0, w * h - 1));
            if (sb.written[a]) begin
               x = cfd_pkg::POS_W'(a % w);
               y = cfd_pkg::POS_W'(a / w);
               return;
            end
         end
         a = sb.recent_address();
         if (a >= 0 && a < w * h) begin
            x = cfd_pkg::POS_W'(a % w);
            y = cfd_pkg::POS_W'(a / w);
            return;
         end
      end
      case ($urandom_range(0, 3))
         0:       x = cfd_pkg::POS_W'(32'h8000 | $urandom);
         1:       x = cfd_pkg::POS_W'(w + $urandom_range(0, 32767 - w));
         2:       y = cfd_pkg::POS_W'(32'h8000 | $urandom);
         default: y = cfd_pkg::POS_W'(h + $urandom_range(0, 32767 - h));
      endcase
   endfunction

   function automatic draw_cmd_type random_command();
      draw_cmd_type                c;
      int                          w;
      int                          h;
      logic [cfd_pkg::POS_W-1:0]   rx;
      logic [cfd_pkg::POS_W-1:0]   ry;
      w = sb.eff_width();
      h = sb.eff_height();
      c.pixel_color = cfd_pkg::COLOR_W'($urandom);
      c.span_length = cfd_pkg::LEN_W'($urandom);
      c.pos_x = pick_coord(w);
      c.pos_y = pick_coord(h);
      case ($urandom_range(0, 3))
         0: c.command = cfd_pkg::CMD_WRITE;
         1: begin
            c.command = cfd_pkg::CMD_READ;
            pick_read(w, h, rx, ry);
            c.pos_x = rx;
            c.pos_y = ry;
         end
         2: begin
            c.command = cfd_pkg::CMD_HSPAN;
            c.span_length = pick_length(w);
         end
         default: begin
            c.command = cfd_pkg::CMD_VSPAN;
            c.span_length = pick_length(h);
         end
      endcase
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_command(input draw_cmd_type c, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.command <= c.command;
      req_chan.pos_x <= c.pos_x;
      req_chan.pos_y <= c.pos_y;
      req_chan.span_length <= c.span_length;
      req_chan.pixel_color <= c.pixel_color;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_command(c);
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_command(random_command(), (i / 32) % 4 == 3);
      end
   endtask

   task automatic write_register(input logic [cfd_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [cfd_pkg::CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(idx, data);
      @(negedge clock);
   endtask

   // The size registers change only once every outstanding result has come back.
   task automatic set_geometry(input logic [cfd_pkg::CSR_W-1:0] wdata,
                               input logic [cfd_pkg::CSR_W-1:0] hdata);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      write_register(cfd_pkg::REG_ACTIVE_WIDTH, wdata);
      write_register(cfd_pkg::REG_ACTIVE_HEIGHT, hdata);
   endtask

   task automatic run_directed();
      // Corners of the default 320 x 240 screen, then clipping on each side.
      send_command(make_cmd(cfd_pkg::CMD_WRITE, 0, 0, 0, 16'hFFFF), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_WRITE, 319, 239, 16'hFFFF, 16'h0000), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 0, 0, 0, 16'h1234), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 319, 239, 0, 16'hFFFF), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_WRITE, 320, 0, 0, 16'h1111), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_WRITE, -1, 5, 0, 16'h2222), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, -32768, 32767, 0, 0), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 5, 240, 0, 0), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, -10, 3, 20, 16'hA5A5), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, 310, 4, 100, 16'h5A5A), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, 0, 5, 0, 16'h3333), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, 0, 6, 65535, 16'h4444), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, -32768, 7, 65535, 16'h8001), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, 5, -1, 10, 16'h5555), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_VSPAN, 7, -5, 10, 16'h6666), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_VSPAN, 8, 235, 100, 16'h7777), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_VSPAN, 9, 0, 65535, 16'hC3C3), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_VSPAN, 320, 0, 5, 16'h9999), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_VSPAN, 32767, 32767, 65535, 16'hAAAA), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 9, 100, 0, 0), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 15, 7, 0, 0), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_WRITE, 100, 100, 0, 16'h5A5A), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 100, 100, 0, 0), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_HSPAN, 319, 239, 1, 16'hBEEF), 1'b0);
      send_command(make_cmd(cfd_pkg::CMD_READ, 319, 239, 0, 0), 1'b0);
   endtask

   initial begin : main_sequence
      logic [cfd_pkg::CSR_W-1:0] fixed_width [7];
      logic [cfd_pkg::CSR_W-1:0] fixed_height [7];
      int                        phase_items [11];
      logic [cfd_pkg::CSR_W-1:0] wdata;
      logic [cfd_pkg::CSR_W-1:0] hdata;
      int                        p;
      req_chan.valid = 1'b0;
      req_chan.command = cfd_pkg::CMD_WRITE;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.span_length = '0;
      req_chan.pixel_color = '0;
      csr_write_enable = 1'b0;
      csr_index = cfd_pkg::REG_ACTIVE_WIDTH;
      csr_write_data = '0;
      // Full size, single pixel, saturating values, the two empty screens, thin strips.
      fixed_width = '{10'd512, 10'd1, 10'd1023, 10'd0, 10'd40, 10'd3, 10'd512};
      fixed_height = '{10'd256, 10'd1, 10'd1023, 10'd100, 10'd0, 10'd256, 10'd1};
      phase_items = '{70, 40, 60, 20, 20, 50, 50, 70, 70, 70, 70};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_random(60);
      for (p = 0; p < 11; p++) begin
         if (p < 7) begin
            wdata = fixed_width[p];
            hdata = fixed_height[p];
         end else begin
            wdata = ($urandom_range(0, 1) != 0) ? cfd_pkg::CSR_W'($urandom_range(1, 64)) :
                                                  cfd_pkg::CSR_W'($urandom_range(65, 512));
            // Bit 9 lies above the height register and must be dropped.
            hdata = cfd_pkg::CSR_W'($urandom_range(1, 256) | ($urandom_range(0, 1) << 9));
         end
         set_geometry(wdata, hdata);
         run_random(phase_items[p]);
      end
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** clipped_framebuffer_draw_top: PASSED **");
      end else begin
         $display("** clipped_framebuffer_draw_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- clipped_framebuffer_draw_top.f -----
hdl/cfd_pkg.sv
hdl/cfd_req_if.sv
hdl/cfd_rsp_if.sv
hdl/cfd_ram.sv
hdl/clipped_framebuffer_draw_top.sv
test/clipped_framebuffer_draw_top_test.sv
